// ===== hw/rtl/lcdpt_pkg.sv =====
// Shared definitions for the page-mode LCD transpose streamer:
// item kinds, controller command bytes and parameter defaults.
// No dependencies.
package lcdpt_pkg;

    // Parameter defaults
    localparam int DEF_BYTES_PER_LINE = 16;
    localparam int DEF_PAGES          = 8;

    // Field widths
    localparam int KIND_W  = 2;
    localparam int VALUE_W = 8;
    localparam int PAGE_W  = 3;
    localparam int BYTE_W  = 8;
    // Page address nibble in the page command
    localparam int PADDR_W = 4;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_PIXELS   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CONTRAST = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INIT     = 2'd2;

    // Controller commands
    localparam logic [BYTE_W-1:0] CMD_PAGE_ADDR = 8'hB0;
    localparam logic [BYTE_W-1:0] CMD_COL_HIGH  = 8'h10;
    localparam logic [BYTE_W-1:0] CMD_COL_LOW   = 8'h04;
    localparam logic [BYTE_W-1:0] CMD_CONTRAST  = 8'h81;
    localparam logic [BYTE_W-1:0] CMD_POWER     = 8'h2F;
    localparam logic [BYTE_W-1:0] CMD_CONTR_VAL = 8'h15;
    localparam logic [BYTE_W-1:0] CMD_BIAS      = 8'hA2;
    localparam logic [BYTE_W-1:0] CMD_SEG_DIR   = 8'hA1;
    localparam logic [BYTE_W-1:0] CMD_COM_DIR   = 8'hC0;
    localparam logic [BYTE_W-1:0] CMD_ALL_OFF   = 8'hA4;
    localparam logic [BYTE_W-1:0] CMD_DISP_ON   = 8'hAF;

    // Controller set-up sequence, eight bytes
    function automatic logic [BYTE_W-1:0] init_cmd(input logic [2:0] idx);
        logic [BYTE_W-1:0] b;
        case (idx)
            3'd0:    b = CMD_POWER;
            3'd1:    b = CMD_CONTRAST;
            3'd2:    b = CMD_CONTR_VAL;
            3'd3:    b = CMD_BIAS;
            3'd4:    b = CMD_SEG_DIR;
            3'd5:    b = CMD_COM_DIR;
            3'd6:    b = CMD_ALL_OFF;
            default: b = CMD_DISP_ON;
        endcase
        return b;
    endfunction

endpackage

// ===== hw/rtl/lcd_page_transpose_streamer.sv =====
// Top level of the page-mode LCD transpose streamer: sequencer, line store
// and output register. Depends on lcdpt_pkg and lcdpt_ram.
//
//  channel | valid   | ready   | payload
//  --------+---------+---------+-------------------------------
//  input   | i_valid | o_ready | i_kind, i_value, i_page
//  output  | o_valid | i_ready | o_out_byte, o_is_data, o_last
//
// Bytes of lines 0..6 are written to the line store; the first byte of a page
// adds three command transfers. A line-7 byte makes seven line-store reads
// through the single read port, waits in S_WAIT for the registered read, then
// sends eight data transfers. Contrast sends two command bytes, init eight.
// Reset is synchronous and clears control state only; the line store is
// not cleared. Output stalls hold the sequencer on the current byte.
module lcd_page_transpose_streamer #(
    parameter int BYTES_PER_LINE = lcdpt_pkg::DEF_BYTES_PER_LINE,
    parameter int PAGES          = lcdpt_pkg::DEF_PAGES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [lcdpt_pkg::KIND_W-1:0]   i_kind,
    input  logic [lcdpt_pkg::VALUE_W-1:0]  i_value,
    input  logic [lcdpt_pkg::PAGE_W-1:0]   i_page,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [lcdpt_pkg::BYTE_W-1:0]   o_out_byte,
    output logic                           o_is_data,
    output logic                           o_last
);
    import lcdpt_pkg::*;

    localparam int STORE_DEPTH = 7 * BYTES_PER_LINE;
    localparam int AW          = $clog2(STORE_DEPTH);
    localparam int COL_W       = (BYTES_PER_LINE > 1) ? $clog2(BYTES_PER_LINE) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMD,
        S_READ,
        S_WAIT,
        S_DATA
    } t_state;

    typedef enum logic [1:0] {
        CS_PAGE,
        CS_CONTRAST,
        CS_INIT
    } t_cmd_sel;

    t_state                 r_state, n_state;
    t_cmd_sel               r_cmd_sel, n_cmd_sel;
    logic [2:0]             r_cnt, n_cnt;
    logic [2:0]             r_cmd_last, n_cmd_last;
    logic [2:0]             r_line, n_line;
    logic [COL_W-1:0]       r_col, n_col;
    logic [AW-1:0]          r_waddr, n_waddr;
    logic [AW-1:0]          r_rd_addr, n_rd_addr;
    logic [PADDR_W-1:0]     r_page, n_page;
    logic [VALUE_W-1:0]     r_value, n_value;
    logic                   r_rd_pend;
    logic [VALUE_W-1:0]     r_lines [7];
    logic                   r_o_valid, n_o_valid;
    logic [BYTE_W-1:0]      r_o_byte, n_o_byte;
    logic                   r_o_is_data, n_o_is_data;
    logic                   r_o_last, n_o_last;

    logic                   accept;
    logic                   out_free;
    logic                   col_last;
    logic                   ram_we;
    logic                   ram_re;
    logic [VALUE_W-1:0]     ram_rdata;
    logic [BYTE_W-1:0]      cmd_byte;
    logic [BYTE_W-1:0]      data_byte;
    logic [PADDR_W-1:0]     page_sat;

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_o_valid || i_ready;
    assign col_last = (r_col == COL_W'(BYTES_PER_LINE - 1));
    assign ram_we   = accept && (i_kind == KIND_PIXELS) && (r_line != 3'd7);
    assign ram_re   = (r_state == S_READ);

    // Line store for lines 0..6 of the current page
    lcdpt_ram #(
        .WIDTH  (VALUE_W),
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (AW)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_waddr),
        .i_wdata (i_value),
        .i_re    (ram_re),
        .i_raddr (r_rd_addr),
        .o_rdata (ram_rdata)
    );

    // Page number saturated to the last page
    always_comb begin
        if ({2'b00, i_page} >= 5'(PAGES)) begin
            page_sat = PADDR_W'(PAGES - 1);
        end else begin
            page_sat = PADDR_W'(i_page);
        end
    end

    // Command byte for the current sequence step
    always_comb begin
        case (r_cmd_sel)
            CS_PAGE: begin
                case (r_cnt)
                    3'd0:    cmd_byte = CMD_PAGE_ADDR | {4'b0000, r_page};
                    3'd1:    cmd_byte = CMD_COL_HIGH;
                    default: cmd_byte = CMD_COL_LOW;
                endcase
            end
            CS_CONTRAST: begin
                if (r_cnt == 3'd0) begin
                    cmd_byte = CMD_CONTRAST;
                end else begin
                    cmd_byte = {2'b00, r_value[7:2]};
                end
            end
            default: cmd_byte = init_cmd(r_cnt);
        endcase
    end

    // Transposed data byte: bit j is bit r_cnt of line j
    always_comb begin
        for (int j = 0; j < 7; j++) begin
            data_byte[j] = r_lines[j][r_cnt];
        end
        data_byte[7] = r_value[r_cnt];
    end

    // Sequencer next state
    always_comb begin
        n_state     = r_state;
        n_cmd_sel   = r_cmd_sel;
        n_cnt       = r_cnt;
        n_cmd_last  = r_cmd_last;
        n_line      = r_line;
        n_col       = r_col;
        n_waddr     = r_waddr;
        n_rd_addr   = r_rd_addr;
        n_page      = r_page;
        n_value     = r_value;
        n_o_valid   = r_o_valid && !i_ready;
        n_o_byte    = r_o_byte;
        n_o_is_data = r_o_is_data;
        n_o_last    = r_o_last;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cnt = 3'd0;
                    case (i_kind)
                        KIND_CONTRAST: begin
                            n_value    = i_value;
                            n_cmd_sel  = CS_CONTRAST;
                            n_cmd_last = 3'd1;
                            n_state    = S_CMD;
                        end
                        KIND_INIT: begin
                            n_cmd_sel  = CS_INIT;
                            n_cmd_last = 3'd7;
                            n_state    = S_CMD;
                        end
                        KIND_PIXELS: begin
                            n_value = i_value;
                            // advance page position
                            if (col_last) begin
                                n_col  = '0;
                                n_line = r_line + 3'd1;
                            end else begin
                                n_col = r_col + COL_W'(1);
                            end
                            if (r_line != 3'd7) begin
                                n_waddr = r_waddr + AW'(1);
                            end else if (col_last) begin
                                n_waddr = '0;
                            end
                            // first byte of a page: page and column commands
                            if (r_line == 3'd0 && r_col == '0) begin
                                n_page     = page_sat;
                                n_cmd_sel  = CS_PAGE;
                                n_cmd_last = 3'd2;
                                n_state    = S_CMD;
                            end else if (r_line == 3'd7) begin
                                n_rd_addr = AW'(r_col);
                                n_state   = S_READ;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_CMD: begin
                if (out_free) begin
                    n_o_valid   = 1'b1;
                    n_o_byte    = cmd_byte;
                    n_o_is_data = 1'b0;
                    n_o_last    = (r_cnt == r_cmd_last);
                    n_cnt       = r_cnt + 3'd1;
                    if (r_cnt == r_cmd_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_READ: begin
                n_rd_addr = r_rd_addr + AW'(BYTES_PER_LINE);
                n_cnt     = r_cnt + 3'd1;
                if (r_cnt == 3'd6) begin
                    n_cnt   = 3'd0;
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                n_state = S_DATA;
            end
            S_DATA: begin
                if (out_free) begin
                    n_o_valid   = 1'b1;
                    n_o_byte    = data_byte;
                    n_o_is_data = 1'b1;
                    n_o_last    = (r_cnt == 3'd7);
                    n_cnt       = r_cnt + 3'd1;
                    if (r_cnt == 3'd7) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_line    <= '0;
            r_col     <= '0;
            r_waddr   <= '0;
            r_rd_pend <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_line    <= n_line;
            r_col     <= n_col;
            r_waddr   <= n_waddr;
            r_rd_pend <= ram_re;
            r_o_valid <= n_o_valid;
        end
        r_cmd_sel   <= n_cmd_sel;
        r_cnt       <= n_cnt;
        r_cmd_last  <= n_cmd_last;
        r_rd_addr   <= n_rd_addr;
        r_page      <= n_page;
        r_value     <= n_value;
        r_o_byte    <= n_o_byte;
        r_o_is_data <= n_o_is_data;
        r_o_last    <= n_o_last;
    end

    // Column of stored lines, shifted in as reads return
    always_ff @(posedge i_clk) begin
        if (r_rd_pend) begin
            for (int k = 0; k < 6; k++) begin
                r_lines[k] <= r_lines[k + 1];
            end
            r_lines[6] <= ram_rdata;
        end
    end

    assign o_valid    = r_o_valid;
    assign o_out_byte = r_o_byte;
    assign o_is_data  = r_o_is_data;
    assign o_last     = r_o_last;

`ifndef SYNTH
    // Store writes and column reads never overlap
    a_no_wr_during_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> !ram_re)
        else $error("line store write during column read");

    // Write address stays inside the store while lines 0..6 arrive
    a_waddr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (32'(r_waddr) < STORE_DEPTH))
        else $error("line store write address out of range");

    // The last column read has returned before data is emitted
    a_read_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT) |-> r_rd_pend)
        else $error("data phase entered without pending read");

    // Data bytes only come out while finishing line 7 of a page
    a_data_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DATA) |-> (r_line == 3'd7 || (r_line == 3'd0 && r_col == '0)))
        else $error("data phase outside line 7");
`endif

endmodule

// ===== hw/rtl/lcdpt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module lcdpt_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 112,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== dv/lcd_page_transpose_streamer_tb.sv =====
// Testbench for lcd_page_transpose_streamer: a queue-fed driver, a monitor with a
// scoreboard and a transfer-level predictor of the page/command/data byte stream.
// Depends on lcdpt_pkg and the streamer RTL.
`timescale 1ns / 1ps

module lcd_page_transpose_streamer_tb;
    import lcdpt_pkg::*;

    localparam int BPL        = DEF_BYTES_PER_LINE;
    localparam int NPAGES     = DEF_PAGES;
    localparam int PAGE_BYTES = 8 * BPL;
    localparam int STORE_SIZE = 7 * BPL;
    localparam int STALL_MAX  = 4000;
    localparam int TAIL_CYC   = 40;

    // Kind code that the block ignores
    localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic [PAGE_W-1:0]  page;
        bit                 drain;  // hold off until the byte stream is drained
    } t_fb_item;

    typedef struct {
        logic [BYTE_W-1:0] lcd_byte;
        logic              is_data;
        logic              last;
    } t_lcd_byte;

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [KIND_W-1:0]    i_kind  = '0;
    logic [VALUE_W-1:0]   i_value = '0;
    logic [PAGE_W-1:0]    i_page  = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [BYTE_W-1:0]    o_out_byte;
    logic                 o_is_data;
    logic                 o_last;

    t_fb_item   pending_items[$];
    t_fb_item   cur_item;
    t_lcd_byte  lcd_bytes_due[$];
    logic [7:0] line_mem[STORE_SIZE];
    int         fb_pos;
    int         items_sent;
    int         bytes_seen;
    int         errors;
    int         stall_cyc;
    logic [BYTE_W-1:0] init_bytes[8];

    lcd_page_transpose_streamer #(
        .BYTES_PER_LINE(BPL),
        .PAGES         (NPAGES)
    ) uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_kind    (i_kind),
        .i_value   (i_value),
        .i_page    (i_page),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_out_byte(o_out_byte),
        .o_is_data (o_is_data),
        .o_last    (o_last)
    );

    // Clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic void queue_lcd_byte(logic [BYTE_W-1:0] b, logic is_data, logic last);
        t_lcd_byte r;
        r.lcd_byte = b;
        r.is_data  = is_data;
        r.last     = last;
        lcd_bytes_due.push_back(r);
    endfunction

    // Expected controller bytes for one accepted item; updates the page position
    // and line store copy.
    function automatic void predict_lcd_bytes(t_fb_item it);
        int          line;
        int          col;
        int          pg;
        logic [7:0]  src;
        logic [7:0]  b;
        case (it.kind)
            KIND_CONTRAST: begin
                queue_lcd_byte(CMD_CONTRAST, 1'b0, 1'b0);
                queue_lcd_byte(it.value >> 2, 1'b0, 1'b1);
            end
            KIND_INIT: begin
                for (int i = 0; i < 8; i++)
                    queue_lcd_byte(init_bytes[i], 1'b0, i == 7);
            end
            KIND_PIXELS: begin
                line = fb_pos / BPL;
                col  = fb_pos % BPL;
                // first byte of a page: page address and column reset
                if (fb_pos == 0) begin
                    pg = (int'(it.page) >= NPAGES) ? NPAGES - 1 : int'(it.page);
                    queue_lcd_byte(CMD_PAGE_ADDR | {4'h0, 4'(pg)}, 1'b0, 1'b0);
                    queue_lcd_byte(CMD_COL_HIGH, 1'b0, 1'b0);
                    queue_lcd_byte(CMD_COL_LOW, 1'b0, 1'b1);
                end
                if (line < 7) begin
                    line_mem[line * BPL + col] = it.value;
                end else begin
                    // 8x8 transpose: bit j of data byte s is bit s of line j
                    for (int s = 0; s < 8; s++) begin
                        b = '0;
                        for (int j = 0; j < 8; j++) begin
                            src  = (j < 7) ? line_mem[j * BPL + col] : it.value;
                            b[j] = src[s];
                        end
                        queue_lcd_byte(b, 1'b1, s == 7);
                    end
                end
                fb_pos = (fb_pos + 1 >= PAGE_BYTES) ? 0 : fb_pos + 1;
            end
            default: ;
        endcase
    endfunction

    function automatic t_fb_item mk_item(logic [KIND_W-1:0] k, logic [VALUE_W-1:0] v,
                                         logic [PAGE_W-1:0] p);
        t_fb_item it;
        it.kind  = k;
        it.value = v;
        it.page  = p;
        it.drain = 1'b0;
        return it;
    endfunction

    function automatic t_fb_item mk_drain();
        t_fb_item it;
        it       = mk_item(KIND_RESERVED, '0, '0);
        it.drain = 1'b1;
        return it;
    endfunction

    // Driver: presents queued items, predicts on each accepted transfer
    always @(posedge i_clk) begin : driver
        bit free_slot;
        bit idle;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                predict_lcd_bytes(cur_item);
                items_sent++;
            end
            free_slot = !i_valid || o_ready;
            if (free_slot) begin
                idle = ($urandom_range(0, 99) < 22) && !(items_sent >= 40 && items_sent < 100);
                if (pending_items.size() > 0 && pending_items[0].drain) begin
                    i_valid <= 1'b0;
                    if (lcd_bytes_due.size() == 0)
                        void'(pending_items.pop_front());
                end else if (pending_items.size() > 0 && !idle) begin
                    cur_item = pending_items.pop_front();
                    i_valid <= 1'b1;
                    i_kind  <= cur_item.kind;
                    i_value <= cur_item.value;
                    i_page  <= cur_item.page;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure and in-order check of every transfer
    always @(posedge i_clk) begin : monitor
        t_lcd_byte want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                bytes_seen++;
                if (lcd_bytes_due.size() == 0) begin
                    errors++;
                    $display("%0t: expected no byte, actual %h is_data %b last %b", $time,
                             o_out_byte, o_is_data, o_last);
                end else begin
                    want = lcd_bytes_due.pop_front();
                    if (o_out_byte !== want.lcd_byte) begin
                        errors++;
                        $display("%0t: out_byte expected %h actual %h", $time,
                                 want.lcd_byte, o_out_byte);
                    end
                    if (o_is_data !== want.is_data) begin
                        errors++;
                        $display("%0t: is_data expected %b actual %b", $time,
                                 want.is_data, o_is_data);
                    end
                    if (o_last !== want.last) begin
                        errors++;
                        $display("%0t: last expected %b actual %b", $time,
                                 want.last, o_last);
                    end
                end
            end
            // no stalls over a stretch of the output stream
            if (bytes_seen >= 20 && bytes_seen < 140)
                i_ready <= 1'b1;
            else
                i_ready <= ($urandom_range(0, 99) >= 22);
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cyc <= 0;
        end else if (stall_cyc >= STALL_MAX) begin
            $display("%0t: no transfer for %0d cycles", $time, stall_cyc);
            $display("Verification failed");
            $finish;
        end else begin
            stall_cyc <= stall_cyc + 1;
        end
    end

    // Stimulus, reset and end of run
    initial begin : stimulus
        int         counted;
        int         r;
        logic [7:0] v;
        fb_pos     = 0;
        items_sent = 0;
        bytes_seen = 0;
        errors     = 0;
        stall_cyc  = 0;
        init_bytes = '{CMD_POWER, CMD_CONTRAST, CMD_CONTR_VAL, CMD_BIAS,
                       CMD_SEG_DIR, CMD_COM_DIR, CMD_ALL_OFF, CMD_DISP_ON};

        // Directed: every kind, field extremes, ignored kind, mid-page commands
        pending_items.push_back(mk_item(KIND_INIT, 8'h00, 3'd0));
        pending_items.push_back(mk_item(KIND_CONTRAST, 8'h00, 3'd0));
        pending_items.push_back(mk_item(KIND_CONTRAST, 8'hFF, 3'd7));
        pending_items.push_back(mk_item(KIND_CONTRAST, 8'h03, 3'd0));
        pending_items.push_back(mk_item(KIND_RESERVED, 8'hFF, 3'd7));
        pending_items.push_back(mk_item(KIND_PIXELS, 8'hFF, 3'd7));
        pending_items.push_back(mk_item(KIND_PIXELS, 8'h00, 3'd0));
        pending_items.push_back(mk_item(KIND_INIT, 8'hFF, 3'd7));
        pending_items.push_back(mk_item(KIND_PIXELS, 8'hA5, 3'd7));
        pending_items.push_back(mk_item(KIND_CONTRAST, 8'h80, 3'd5));
        pending_items.push_back(mk_item(KIND_RESERVED, 8'h00, 3'd0));
        pending_items.push_back(mk_item(KIND_PIXELS, 8'h5A, 3'd2));
        pending_items.push_back(mk_drain());
        counted = 10;

        // Random: mostly framebuffer bytes, with commands and noise mixed in
        while (counted < 180) begin
            r = $urandom_range(0, 99);
            case ($urandom_range(0, 7))
                0:       v = 8'h00;
                1:       v = 8'hFF;
                default: v = 8'($urandom);
            endcase
            if (r < 6) begin
                pending_items.push_back(mk_item(KIND_CONTRAST, v, 3'($urandom)));
                counted++;
            end else if (r < 10) begin
                pending_items.push_back(mk_item(KIND_INIT, v, 3'($urandom)));
                counted++;
            end else if (r < 13) begin
                pending_items.push_back(mk_item(KIND_RESERVED, v, 3'($urandom)));
            end else begin
                pending_items.push_back(mk_item(KIND_PIXELS, v, 3'($urandom)));
                counted++;
            end
            if (counted == 95)
                pending_items.push_back(mk_drain());
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_items.size() == 0 && !i_valid);
        wait (lcd_bytes_due.size() == 0);
        repeat (TAIL_CYC) @(posedge i_clk);

        if (errors == 0 && lcd_bytes_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
